### hw/rtl/priority_software_timer_bank_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority software timer bank
// Shared property forms used by the checker of the timer bank.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SOFTWARE_TIMER_BANK_TOP_DEFINES_SVH
`define PRIORITY_SOFTWARE_TIMER_BANK_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSTB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pstb_pkg.sv
// ----------------------------------------------------------------------------
// Priority software timer bank package
// Sizes, action codes and the types shared by the timer bank modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pstb_pkg;

    localparam int NUM_CHANNELS     = 7;
    localparam int COUNT_WIDTH      = 16;
    localparam int TIMEOUT_WIDTH    = 16;
    localparam int NUM_TIMEOUT_REGS = 7;
    localparam int CMP_WIDTH        = (COUNT_WIDTH > TIMEOUT_WIDTH) ? COUNT_WIDTH
                                                                    : TIMEOUT_WIDTH;
    localparam int ACTION_WIDTH     = 2;
    localparam int CHANNEL_WIDTH    = 3;
    localparam int CFG_INDEX_WIDTH  = 3;

    localparam logic [ACTION_WIDTH-1:0] ACT_TICK     = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_START    = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_STOP     = 2'd2;
    localparam logic [ACTION_WIDTH-1:0] ACT_STOP_ALL = 2'd3;

    typedef struct packed {
        logic [ACTION_WIDTH-1:0]  action;
        logic [CHANNEL_WIDTH-1:0] channel;
        logic                     auto_restart;
        logic                     check_expiry;
    } pstb_cmd_t;

    typedef struct packed {
        logic                     fired;
        logic [CHANNEL_WIDTH-1:0] fired_channel;
    } pstb_res_t;

endpackage

`default_nettype wire

### hw/rtl/pstb_core.sv
// ----------------------------------------------------------------------------
// Timer bank core
// Holds the channel counters, flags and timeouts, and applies one command.
// ----------------------------------------------------------------------------
`default_nettype none

module pstb_core
    import pstb_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [TIMEOUT_WIDTH-1:0]   cfg_data,
    input  wire logic                       cmd_valid,
    input  wire pstb_cmd_t                  cmd,
    output pstb_res_t                       res
);

    logic [COUNT_WIDTH-1:0]   count_reg   [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]   count_next  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]   count_inc   [NUM_CHANNELS];
    logic [TIMEOUT_WIDTH-1:0] timeout_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  running_reg;
    logic [NUM_CHANNELS-1:0]  running_next;
    logic [NUM_CHANNELS-1:0]  restart_reg;
    logic [NUM_CHANNELS-1:0]  restart_next;
    logic                     any_started_reg;
    logic                     any_started_next;
    logic [NUM_CHANNELS-1:0]  hit;
    logic                     tick_go;
    logic                     fire;
    logic [CHANNEL_WIDTH-1:0] sel;

    assign tick_go = (cmd.action == ACT_TICK) && any_started_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (running_reg[i] && (count_reg[i] != {COUNT_WIDTH{1'b1}}))
            begin
                count_inc[i] = count_reg[i] + 1'b1;
            end
            else
            begin
                count_inc[i] = count_reg[i];
            end
            hit[i] = tick_go && cmd.check_expiry && running_reg[i] &&
                     (CMP_WIDTH'(count_inc[i]) >= CMP_WIDTH'(timeout_reg[i]));
        end
    end

    always_comb
    begin
        fire = 1'b0;
        sel  = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                fire = 1'b1;
                sel  = CHANNEL_WIDTH'(i);
            end
        end
    end

    assign res.fired         = fire;
    assign res.fired_channel = sel;

    always_comb
    begin
        count_next       = count_reg;
        running_next     = running_reg;
        restart_next     = restart_reg;
        any_started_next = any_started_reg;
        case (cmd.action)
            ACT_TICK:
            begin
                if (any_started_reg)
                begin
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        count_next[i] = count_inc[i];
                        if (fire && (int'(sel) == i))
                        begin
                            count_next[i] = '0;
                            if (!restart_reg[i])
                            begin
                                running_next[i] = 1'b0;
                            end
                        end
                    end
                end
            end
            ACT_START:
            begin
                any_started_next = 1'b1;
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (int'(cmd.channel) == i)
                    begin
                        count_next[i]   = '0;
                        running_next[i] = 1'b1;
                        restart_next[i] = cmd.auto_restart;
                    end
                end
            end
            ACT_STOP:
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (int'(cmd.channel) == i)
                    begin
                        count_next[i]   = '0;
                        running_next[i] = 1'b0;
                    end
                end
            end
            default:
            begin
                any_started_next = 1'b0;
                running_next     = '0;
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    count_next[i] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                count_reg[i] <= '0;
            end
            running_reg     <= '0;
            restart_reg     <= '0;
            any_started_reg <= 1'b0;
        end
        else if (cmd_valid)
        begin
            count_reg       <= count_next;
            running_reg     <= running_next;
            restart_reg     <= restart_next;
            any_started_reg <= any_started_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                timeout_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if ((i < NUM_TIMEOUT_REGS) && (int'(cfg_index) == i))
                begin
                    timeout_reg[i] <= cfg_data;
                end
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/priority_software_timer_bank_top.sv
// ----------------------------------------------------------------------------
// Priority software timer bank
// Command stream in, one expiry report out for every command.
// ----------------------------------------------------------------------------
// The input stream carries commands: tuser holds the action (tick, start
// channel, stop channel, stop all) and tdata the channel, restart and check
// bits. Every accepted command yields exactly one output transaction whose
// tuser says whether a channel fired and whose tdata holds its index.
// A tick advances all running counters, which saturate, and with checking on
// the lowest-numbered channel that reached its timeout fires and then
// restarts or stops.
// Timeouts are written through the configuration channel, which is always
// ready; write them only while no command is in flight.
// A command passes through one input register, then the channel update and
// priority pick feed the result register. One command is taken every cycle
// while the output is drained.
// When the receiver stalls, the result register holds and the input register
// takes one more command before the input side stops.
// Reset stops every channel, clears all counters and timeouts, and empties
// both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_software_timer_bank_top
    import pstb_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output      logic                       s_tready,
    input  wire logic [7:0]                 s_tdata,   // channel, auto_restart, check_expiry
    input  wire logic [ACTION_WIDTH-1:0]    s_tuser,   // action
    output      logic                       m_tvalid,
    input  wire logic                       m_tready,
    output      logic [7:0]                 m_tdata,   // fired_channel
    output      logic [0:0]                 m_tuser,   // fired
    input  wire logic                       cfg_valid,
    output      logic                       cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [TIMEOUT_WIDTH-1:0]   cfg_data
);

    logic      in_valid_reg;
    pstb_cmd_t in_cmd_reg;
    logic      out_valid_reg;
    pstb_res_t out_res_reg;
    pstb_res_t core_res;
    logic      proc_go;

    assign proc_go   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_go;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg.action       <= s_tuser;
            in_cmd_reg.channel      <= s_tdata[CHANNEL_WIDTH-1:0];
            in_cmd_reg.auto_restart <= s_tdata[CHANNEL_WIDTH];
            in_cmd_reg.check_expiry <= s_tdata[CHANNEL_WIDTH+1];
        end
    end

    pstb_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (proc_go),
        .cmd       (in_cmd_reg),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 8'(out_res_reg.fired_channel);
    assign m_tuser  = out_res_reg.fired;

endmodule

`default_nettype wire

### hw/rtl/pstb_checker.sv
// ----------------------------------------------------------------------------
// Timer bank port checker
// Watches the output stream of the timer bank for inconsistent reports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_software_timer_bank_top_defines.svh"

module pstb_checker
    import pstb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [0:0] m_tuser
);

    `PSTB_ASSERT_SAME(a_idle_index_zero, m_tvalid && !m_tuser[0], m_tdata == 8'd0, "report without expiry carries a nonzero index")
    `PSTB_ASSERT_SAME(a_fired_in_range, m_tvalid && m_tuser[0], int'(m_tdata) < NUM_CHANNELS, "expired channel index out of range")
    `PSTB_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output transaction changed")

endmodule

bind priority_software_timer_bank_top pstb_checker u_checker (.*);

`default_nettype wire

### verif/tb_priority_software_timer_bank_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the priority software timer bank
// Streams timer commands into the bank and compares every expiry report with
// a cycle-free model of the channels kept inside the testbench. Timeouts are
// reprogrammed between phases that differ in how often the command side
// idles and the report side stalls.
// ----------------------------------------------------------------------------

module tb_priority_software_timer_bank_top;
    import pstb_pkg::*;

    localparam int RESET_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int NUM_PHASES      = 4;
    localparam int MAX_PRINTED     = 50;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata   = '0;   // channel, auto_restart, check_expiry
    logic [ACTION_WIDTH-1:0]    s_tuser   = '0;   // action
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [7:0]                 m_tdata;          // fired_channel
    logic [0:0]                 m_tuser;          // fired
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [TIMEOUT_WIDTH-1:0]   cfg_data  = '0;

    pstb_cmd_t pending_cmds[$];
    pstb_res_t expected_reports[$];

    logic [COUNT_WIDTH-1:0]   chan_count   [NUM_CHANNELS];
    logic                     chan_running [NUM_CHANNELS];
    logic                     chan_restart [NUM_CHANNELS];
    logic [TIMEOUT_WIDTH-1:0] chan_timeout [NUM_CHANNELS];
    logic                     bank_started;

    bit cmd_taken   = 1'b0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int idle_cycles = 0;
    int mismatches  = 0;
    int cmds_sent   = 0;
    int reports_got = 0;
    int expiries    = 0;
    int reg_writes  = 0;

    priority_software_timer_bank_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic pstb_res_t timer_bank_step(input pstb_cmd_t c);
        pstb_res_t r;
        bit        found;
        int        i;
        r     = '0;
        found = 1'b0;
        case (c.action)
            ACT_TICK:
            begin
                if (bank_started)
                begin
                    for (i = 0; i < NUM_CHANNELS; i++)
                    begin
                        if (chan_running[i] && chan_count[i] < COUNT_MAX)
                            chan_count[i] = chan_count[i] + 1'b1;
                    end
                    if (c.check_expiry)
                    begin
                        for (i = 0; i < NUM_CHANNELS; i++)
                        begin
                            if (!found && chan_running[i] && chan_count[i] >= chan_timeout[i])
                            begin
                                chan_count[i] = '0;
                                if (!chan_restart[i])
                                    chan_running[i] = 1'b0;
                                r.fired         = 1'b1;
                                r.fired_channel = CHANNEL_WIDTH'(i);
                                found           = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_START:
            begin
                bank_started = 1'b1;
                if (c.channel < NUM_CHANNELS)
                begin
                    chan_count[c.channel]   = '0;
                    chan_running[c.channel] = 1'b1;
                    chan_restart[c.channel] = c.auto_restart;
                end
            end
            ACT_STOP:
            begin
                if (c.channel < NUM_CHANNELS)
                begin
                    chan_running[c.channel] = 1'b0;
                    chan_count[c.channel]   = '0;
                end
            end
            default:
            begin
                bank_started = 1'b0;
                for (i = 0; i < NUM_CHANNELS; i++)
                begin
                    chan_running[i] = 1'b0;
                    chan_count[i]   = '0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns: %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    endtask

    task automatic queue_cmd(input logic [ACTION_WIDTH-1:0] act,
                             input logic [CHANNEL_WIDTH-1:0] ch,
                             input logic rs, input logic chk);
        pstb_cmd_t c;
        c.action       = act;
        c.channel      = ch;
        c.auto_restart = rs;
        c.check_expiry = chk;
        pending_cmds.push_back(c);
    endtask

    function automatic pstb_cmd_t random_cmd();
        pstb_cmd_t c;
        int        r;
        r = $urandom_range(99);
        if (r < 55)
            c.action = ACT_TICK;
        else if (r < 80)
            c.action = ACT_START;
        else if (r < 95)
            c.action = ACT_STOP;
        else
            c.action = ACT_STOP_ALL;
        c.channel      = CHANNEL_WIDTH'($urandom_range(7));
        c.auto_restart = 1'($urandom_range(1));
        c.check_expiry = ($urandom_range(9) < 7);
        return c;
    endfunction

    function automatic logic [TIMEOUT_WIDTH-1:0] pick_timeout();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return TIMEOUT_WIDTH'($urandom);
            default: return TIMEOUT_WIDTH'($urandom_range(12, 1));
        endcase
    endfunction

    task automatic write_reg(input int idx, input logic [TIMEOUT_WIDTH-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INDEX_WIDTH'(idx);
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : driver
        pstb_cmd_t c;
        if (!s_tvalid || cmd_taken)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                c = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= c.action;
                s_tdata  <= {3'b000, c.check_expiry, c.auto_restart, c.channel};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        pstb_res_t want;
        pstb_cmd_t seen;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                reports_got++;
                if (expected_reports.size() == 0)
                begin
                    report_mismatch("report with no command waiting", m_tdata, 8'h00);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (want.fired)
                        expiries++;
                    if (m_tuser[0] !== want.fired)
                        report_mismatch("fired flag", {7'd0, m_tuser[0]}, {7'd0, want.fired});
                    if (m_tdata !== {{(8 - CHANNEL_WIDTH){1'b0}}, want.fired_channel})
                        report_mismatch("fired channel", m_tdata,
                                        {{(8 - CHANNEL_WIDTH){1'b0}}, want.fired_channel});
                end
            end
            cmd_taken = s_tvalid && s_tready;
            if (cmd_taken)
            begin
                moved             = 1'b1;
                seen.action       = s_tuser;
                seen.channel      = s_tdata[2:0];
                seen.auto_restart = s_tdata[3];
                seen.check_expiry = s_tdata[4];
                expected_reports.push_back(timer_bank_step(seen));
                cmds_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                reg_writes++;
                if (cfg_index < NUM_TIMEOUT_REGS && cfg_index < NUM_CHANNELS)
                    chan_timeout[cfg_index] = cfg_data;
            end
            if (moved)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Watchdog: no transaction for %0d cycles, %0d reports pending.",
                             idle_cycles, expected_reports.size());
                    $display("priority_software_timer_bank_top verification failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        int idle_by_phase [NUM_PHASES];
        int stall_by_phase[NUM_PHASES];
        int p;
        int i;
        idle_by_phase  = '{0, 77, 0, 8};
        stall_by_phase = '{0, 0, 77, 8};
        for (i = 0; i < NUM_CHANNELS; i++)
        begin
            chan_count[i]   = '0;
            chan_running[i] = 1'b0;
            chan_restart[i] = 1'b0;
            chan_timeout[i] = '0;
        end
        bank_started = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_cmd(ACT_TICK, 3'd5, 1'b1, 1'b1);
        wait_idle();

        write_reg(0, 16'h0000);
        write_reg(1, 16'd3);
        write_reg(2, 16'hFFFF);
        write_reg(3, 16'd1);
        write_reg(4, 16'd2);
        write_reg(5, 16'hFFFF);
        write_reg(6, 16'd5);
        write_reg(7, 16'h1234);

        queue_cmd(ACT_START,    3'd7, 1'b1, 1'b0);
        queue_cmd(ACT_TICK,     3'd0, 1'b0, 1'b1);
        queue_cmd(ACT_START,    3'd0, 1'b0, 1'b0);
        queue_cmd(ACT_START,    3'd1, 1'b1, 1'b1);
        queue_cmd(ACT_TICK,     3'd7, 1'b1, 1'b1);
        queue_cmd(ACT_TICK,     3'd2, 1'b0, 1'b0);
        queue_cmd(ACT_TICK,     3'd0, 1'b0, 1'b1);
        queue_cmd(ACT_TICK,     3'd0, 1'b0, 1'b1);
        queue_cmd(ACT_STOP,     3'd1, 1'b1, 1'b1);
        queue_cmd(ACT_STOP,     3'd7, 1'b0, 1'b0);
        queue_cmd(ACT_START,    3'd6, 1'b1, 1'b0);
        queue_cmd(ACT_START,    3'd5, 1'b0, 1'b1);
        queue_cmd(ACT_START,    3'd3, 1'b0, 1'b0);
        queue_cmd(ACT_TICK,     3'd0, 1'b0, 1'b1);
        queue_cmd(ACT_TICK,     3'd0, 1'b1, 1'b1);
        queue_cmd(ACT_STOP_ALL, 3'd4, 1'b1, 1'b1);
        queue_cmd(ACT_TICK,     3'd0, 1'b0, 1'b1);
        queue_cmd(ACT_START,    3'd4, 1'b1, 1'b0);
        queue_cmd(ACT_TICK,     3'd0, 1'b0, 1'b1);
        queue_cmd(ACT_TICK,     3'd0, 1'b0, 1'b1);
        queue_cmd(ACT_TICK,     3'd0, 1'b0, 1'b1);
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            for (i = 0; i < NUM_CHANNELS; i++)
            begin
                if (p == NUM_PHASES - 1)
                    write_reg(i, $urandom_range(1) ? 16'hFFFF : 16'h0000);
                else
                    write_reg(i, pick_timeout());
            end
            write_reg(7, TIMEOUT_WIDTH'($urandom));
            idle_pct  = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                pending_cmds.push_back(random_cmd());
            wait_idle();
        end

        repeat (8) @(posedge clk);

        if (expected_reports.size() != 0)
            report_mismatch("reports never delivered", 8'(expected_reports.size()), 8'h00);

        $display("Sent %0d commands and checked %0d reports, %0d of them expiries, with %0d register writes.",
                 cmds_sent, reports_got, expiries, reg_writes);
        $display("Ran a directed sequence and %0d handshake pressure phases; %0d mismatches.",
                 NUM_PHASES, mismatches);
        if (mismatches == 0)
            $display("priority_software_timer_bank_top verification clean");
        else
            $display("priority_software_timer_bank_top verification failed");
        $finish;
    end

endmodule
